/* hdl/cpisc_pkg.sv */
// Shared types and constants for the cascaded PI speed and current controller.
`default_nettype none
package cpisc_pkg;

  localparam int SIG_W     = 32;
  localparam int GAIN_W    = 32;
  localparam int PROD_W    = SIG_W + GAIN_W;
  localparam int ACC_W     = 42;
  localparam int CFG_IDX_W = 3;
  localparam int RND_SHIFT = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI_DT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_KP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_KI_DT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EMF_CONSTANT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_CEILING = 3'd5;

  localparam logic signed [GAIN_W-1:0] RST_SPEED_KP        = 32'sd4194304;
  localparam logic signed [GAIN_W-1:0] RST_SPEED_KI_DT     = 32'sd1049;
  localparam logic signed [GAIN_W-1:0] RST_CURRENT_KP      = 32'sd83886080;
  localparam logic signed [GAIN_W-1:0] RST_CURRENT_KI_DT   = 32'sd209715;
  localparam logic signed [GAIN_W-1:0] RST_EMF_CONSTANT    = 32'sd16777216;
  localparam logic signed [SIG_W-1:0]  RST_VOLTAGE_CEILING = 32'sd6553600;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_KIS,
    ST_INT_S,
    ST_TGT,
    ST_ERR_C,
    ST_MUL_KIC,
    ST_INT_C,
    ST_VSUM,
    ST_VOUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_INT_S,
    OP_TGT,
    OP_ERR_C,
    OP_INT_C,
    OP_VSUM,
    OP_VOUT
  } dp_op_t;

  typedef enum logic [2:0] {
    MSEL_NONE,
    MSEL_KI_S,
    MSEL_KP_S,
    MSEL_KI_C,
    MSEL_KP_C,
    MSEL_EMF
  } msel_t;

  typedef struct packed {
    dp_op_t op;
    msel_t  msel;
  } dp_cmd_t;

endpackage
`default_nettype wire

/* hdl/cpisc_dp.sv */
// Datapath: gain registers, shared multiplier, integrators and result registers.
`default_nettype none
module cpisc_dp #(
  parameter int SIGNAL_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [cpisc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cpisc_pkg::SIG_W-1:0]         cfg_data,
  input  wire cpisc_pkg::dp_cmd_t                  cmd,
  input  wire logic signed [cpisc_pkg::SIG_W-1:0]  in_target,
  input  wire logic signed [cpisc_pkg::SIG_W-1:0]  in_speed,
  input  wire logic signed [cpisc_pkg::SIG_W-1:0]  in_current,
  output logic signed [cpisc_pkg::SIG_W-1:0]       vcmd,
  output logic signed [cpisc_pkg::SIG_W-1:0]       itgt,
  output logic                                     vclamp
);
  import cpisc_pkg::*;

  localparam int SIG_BITS = (SIGNAL_WIDTH > SIG_W) ? SIG_W :
                            ((SIGNAL_WIDTH < 2) ? 2 : SIGNAL_WIDTH);
  localparam logic signed [ACC_W-1:0] SIG_HI =
    ACC_W'((64'sd1 <<< (SIG_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SIG_LO = -SIG_HI - ACC_W'(1);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (RND_SHIFT - 1));

  logic signed [GAIN_W-1:0] kp_s_r, ki_s_r, kp_c_r, ki_c_r, emf_r;
  logic signed [SIG_W-1:0]  ceil_r;
  logic signed [SIG_W-1:0]  si_r, ci_r;
  logic signed [SIG_W-1:0]  spd_r, cur_r, es_r, it_r, ei_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SIG_W-1:0]  vcmd_r, itgt_r;
  logic                     vclamp_r;

  logic signed [GAIN_W-1:0] mul_a;
  logic signed [SIG_W-1:0]  mul_b;
  logic signed [ACC_W-1:0]  prod_q;
  logic signed [SIG_W-1:0]  v_sat;

  function automatic logic signed [ACC_W-1:0] ext(input logic signed [SIG_W-1:0] x);
    return ACC_W'(x);
  endfunction

  function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] x);
    logic signed [SIG_W-1:0] r;
    if (x > SIG_HI) begin
      r = SIG_W'(SIG_HI);
    end else if (x < SIG_LO) begin
      r = SIG_W'(SIG_LO);
    end else begin
      r = SIG_W'(x);
    end
    return r;
  endfunction

  always_comb begin
    case (cmd.msel)
      MSEL_KI_S: begin mul_a = ki_s_r; mul_b = es_r;  end
      MSEL_KP_S: begin mul_a = kp_s_r; mul_b = es_r;  end
      MSEL_KI_C: begin mul_a = ki_c_r; mul_b = ei_r;  end
      MSEL_KP_C: begin mul_a = kp_c_r; mul_b = ei_r;  end
      MSEL_EMF:  begin mul_a = emf_r;  mul_b = spd_r; end
      default:   begin mul_a = '0;     mul_b = '0;    end
    endcase
  end

  assign prod_q = ACC_W'((prod_r + RND_HALF) >>> RND_SHIFT);
  assign v_sat  = sat_sig(acc_r + prod_q);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_s_r <= RST_SPEED_KP;
      ki_s_r <= RST_SPEED_KI_DT;
      kp_c_r <= RST_CURRENT_KP;
      ki_c_r <= RST_CURRENT_KI_DT;
      emf_r  <= RST_EMF_CONSTANT;
      ceil_r <= RST_VOLTAGE_CEILING;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_KP:        kp_s_r <= cfg_data;
        REG_SPEED_KI_DT:     ki_s_r <= cfg_data;
        REG_CURRENT_KP:      kp_c_r <= cfg_data;
        REG_CURRENT_KI_DT:   ki_c_r <= cfg_data;
        REG_EMF_CONSTANT:    emf_r  <= cfg_data;
        REG_VOLTAGE_CEILING: ceil_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_r <= '0;
      ci_r <= '0;
    end else begin
      if (cmd.op == OP_INT_S) begin
        si_r <= sat_sig(ext(si_r) + prod_q);
      end
      if (cmd.op == OP_INT_C) begin
        ci_r <= sat_sig(ext(ci_r) + prod_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.msel != MSEL_NONE) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    case (cmd.op)
      OP_LOAD: begin
        spd_r <= in_speed;
        cur_r <= in_current;
        es_r  <= sat_sig(ext(in_target) - ext(in_speed));
      end
      OP_TGT:   it_r  <= sat_sig(prod_q + ext(si_r));
      OP_ERR_C: ei_r  <= sat_sig(ext(it_r) - ext(cur_r));
      OP_VSUM:  acc_r <= prod_q + ext(ci_r);
      OP_VOUT: begin
        itgt_r <= it_r;
        if (v_sat > ceil_r) begin
          vcmd_r   <= ceil_r;
          vclamp_r <= 1'b1;
        end else begin
          vcmd_r   <= v_sat;
          vclamp_r <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign vcmd   = vcmd_r;
  assign itgt   = itgt_r;
  assign vclamp = vclamp_r;

endmodule
`default_nettype wire

/* hdl/cpisc_ctrl.sv */
// Controller: sequences one control update and manages both stream handshakes.
`default_nettype none
module cpisc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output cpisc_pkg::dp_cmd_t  cmd
);
  import cpisc_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd.op        = OP_NONE;
    cmd.msel      = MSEL_NONE;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_MUL_KIS;
        end
      end
      ST_MUL_KIS: begin
        cmd.msel  = MSEL_KI_S;
        state_nxt = ST_INT_S;
      end
      ST_INT_S: begin
        cmd.op    = OP_INT_S;
        cmd.msel  = MSEL_KP_S;
        state_nxt = ST_TGT;
      end
      ST_TGT: begin
        cmd.op    = OP_TGT;
        state_nxt = ST_ERR_C;
      end
      ST_ERR_C: begin
        cmd.op    = OP_ERR_C;
        state_nxt = ST_MUL_KIC;
      end
      ST_MUL_KIC: begin
        cmd.msel  = MSEL_KI_C;
        state_nxt = ST_INT_C;
      end
      ST_INT_C: begin
        cmd.op    = OP_INT_C;
        cmd.msel  = MSEL_KP_C;
        state_nxt = ST_VSUM;
      end
      ST_VSUM: begin
        cmd.op    = OP_VSUM;
        cmd.msel  = MSEL_EMF;
        state_nxt = ST_VOUT;
      end
      ST_VOUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_VOUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

/* hdl/cascaded_pi_speed_current_control.sv */
// Top level of the cascaded PI speed and current controller for a DC motor.
// One input transaction carries speed target, measured speed and measured current (Q16.16);
// one result transaction returns the clamped voltage command, the current target and a flag
// set when the voltage ceiling replaced the command. Five gain products pass one at a time
// through a single registered 32x32 multiplier, with the integrator, error and sum steps
// between them. The next input is taken once the previous update has moved to the output
// register, so no transaction is accepted while an update is in progress; a full output
// register stalls that move. Gains (Q8.24) and the ceiling (Q16.16) are written over the
// cfg port; the user must write them only while the block is idle; the block never checks.
// SIGNAL_WIDTH sets the saturation range of every internal sum and both integrators.
`default_nettype none
module cascaded_pi_speed_current_control #(
  parameter int SIGNAL_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // speed_target [31:0], speed_measured [63:32], current_measured [95:64]
  input  wire logic [3*cpisc_pkg::SIG_W-1:0]       in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // voltage_command [31:0], current_target [63:32]
  output logic [2*cpisc_pkg::SIG_W-1:0]            out_tdata,
  // voltage_clamped [0]
  output logic [0:0]                               out_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cpisc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cpisc_pkg::SIG_W-1:0]         cfg_data
);
  import cpisc_pkg::*;

  dp_cmd_t                 cmd;
  logic signed [SIG_W-1:0] vcmd, itgt;
  logic                    vclamp;

  assign cfg_ready = 1'b1;

  cpisc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  cpisc_dp #(
    .SIGNAL_WIDTH (SIGNAL_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .in_target  (in_tdata[SIG_W-1:0]),
    .in_speed   (in_tdata[2*SIG_W-1:SIG_W]),
    .in_current (in_tdata[3*SIG_W-1:2*SIG_W]),
    .vcmd       (vcmd),
    .itgt       (itgt),
    .vclamp     (vclamp)
  );

  assign out_tdata = {itgt, vcmd};
  assign out_tuser = vclamp;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an update is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_VOUT) |-> (!out_tvalid || out_tready))
    else $error("result register overwritten before transaction");

  a_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (cmd.msel == MSEL_NONE))
    else $error("multiplier issued while accepting input");

  a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_VOUT) |=> out_tvalid)
    else $error("result loaded without valid");

endmodule
`default_nettype wire

/* tb/cascaded_pi_speed_current_control_test.sv */
// Self-checking testbench for the cascaded PI speed and current controller.
module cascaded_pi_speed_current_control_test;
  import cpisc_pkg::*;

  localparam int SIGNAL_WIDTH = 32;
  localparam int SIG_BITS = SIGNAL_WIDTH > 32 ? 32 : (SIGNAL_WIDTH < 2 ? 2 : SIGNAL_WIDTH);
  localparam longint SIG_MAX = (longint'(1) <<< (SIG_BITS - 1)) - 1;
  localparam longint SIG_MIN = -SIG_MAX - 1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [SIG_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SIG_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [SIG_W-1:0] Q_100 = 32'sd6553600;

  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int N_DIRECTED    = 21;

  typedef struct packed {
    logic signed [SIG_W-1:0] voltage_command;
    logic signed [SIG_W-1:0] current_target;
    logic                    voltage_clamped;
  } ctrl_result_t;

  typedef struct packed {
    logic signed [SIG_W-1:0] target;
    logic signed [SIG_W-1:0] speed;
    logic signed [SIG_W-1:0] current;
    logic                    typed;
    ctrl_result_t            expected;
  } stim_row_t;

  localparam ctrl_result_t NO_RESULT = '0;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  wire                    in_tready;
  logic [3*SIG_W-1:0]     in_tdata = '0;
  wire                    out_tvalid;
  logic                   out_tready = 1'b0;
  wire  [2*SIG_W-1:0]     out_tdata;
  wire  [0:0]             out_tuser;
  logic                   cfg_valid = 1'b0;
  wire                    cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SIG_W-1:0]       cfg_data = '0;

  logic signed [GAIN_W-1:0] speed_kp_q   = RST_SPEED_KP;
  logic signed [GAIN_W-1:0] speed_ki_q   = RST_SPEED_KI_DT;
  logic signed [GAIN_W-1:0] current_kp_q = RST_CURRENT_KP;
  logic signed [GAIN_W-1:0] current_ki_q = RST_CURRENT_KI_DT;
  logic signed [GAIN_W-1:0] emf_q        = RST_EMF_CONSTANT;
  logic signed [SIG_W-1:0]  ceiling_q    = RST_VOLTAGE_CEILING;
  longint                   speed_integ   = 0;
  longint                   current_integ = 0;

  ctrl_result_t pending_results[$];
  ctrl_result_t head_result;
  int           fault_count = 0;
  bit           idle_on = 1'b1;
  bit           hold_request = 1'b0;

  stim_row_t stim_table [N_DIRECTED] = '{
    '{32'sd0, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
    '{32'sd0, 32'sd0, Q_MIN,  1'b1, '{RST_VOLTAGE_CEILING, 32'sd0, 1'b1}},
    '{32'sd0, 32'sd0, Q_MAX,  1'b1, '{Q_MIN, 32'sd0, 1'b0}},
    '{Q_MAX, Q_MIN, 32'sd0, 1'b0, NO_RESULT},
    '{Q_MIN, Q_MAX, 32'sd0, 1'b0, NO_RESULT},
    '{Q_MAX, Q_MAX, Q_MAX, 1'b0, NO_RESULT},
    '{Q_MIN, Q_MIN, Q_MIN, 1'b0, NO_RESULT},
    '{-32'sd1, -32'sd1, -32'sd1, 1'b0, NO_RESULT},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, NO_RESULT},
    '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, NO_RESULT},
    '{32'sd1, 32'sd0, -32'sd1, 1'b0, NO_RESULT},
    '{Q_100, 32'sd0, 32'sd0, 1'b0, NO_RESULT},
    '{Q_100, 32'sd3276800, 32'sd655360, 1'b0, NO_RESULT},
    '{Q_100, Q_100, 32'sd0, 1'b0, NO_RESULT},
    '{32'sd0, Q_100, 32'sd0, 1'b0, NO_RESULT},
    '{32'sd0, Q_MIN, 32'sd0, 1'b0, NO_RESULT},
    '{32'sd0, Q_MAX, 32'sd0, 1'b0, NO_RESULT},
    '{-Q_100, 32'sd0, 32'sd0, 1'b0, NO_RESULT},
    '{Q_MAX, 32'sd0, Q_MAX, 1'b0, NO_RESULT},
    '{32'sd0, 32'sd0, 32'sd0, 1'b0, NO_RESULT},
    '{32'sh0000_8000, 32'shFFFF_8000, 32'sd0, 1'b0, NO_RESULT}
  };

  cascaded_pi_speed_current_control #(
    .SIGNAL_WIDTH(SIGNAL_WIDTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clip_sig(input longint v);
    if (v > SIG_MAX) return SIG_MAX;
    if (v < SIG_MIN) return SIG_MIN;
    return v;
  endfunction

  function automatic longint gain_times(input logic signed [GAIN_W-1:0] gain, input longint sig);
    longint q;
    q = longint'(gain) * sig + (longint'(1) <<< (RND_SHIFT - 1));
    return q >>> RND_SHIFT;
  endfunction

  function automatic ctrl_result_t control_tick(input logic signed [SIG_W-1:0] target,
                                                input logic signed [SIG_W-1:0] speed,
                                                input logic signed [SIG_W-1:0] current);
    longint       es;
    longint       ei;
    longint       itarget;
    longint       v;
    ctrl_result_t r;
    es = clip_sig(longint'(target) - longint'(speed));
    speed_integ = clip_sig(speed_integ + gain_times(speed_ki_q, es));
    itarget = clip_sig(gain_times(speed_kp_q, es) + speed_integ);
    ei = clip_sig(itarget - longint'(current));
    current_integ = clip_sig(current_integ + gain_times(current_ki_q, ei));
    v = clip_sig(gain_times(current_kp_q, ei) + current_integ
                 + gain_times(emf_q, longint'(speed)));
    r.voltage_clamped = (v > longint'(ceiling_q));
    if (r.voltage_clamped) v = longint'(ceiling_q);
    r.voltage_command = v[SIG_W-1:0];
    r.current_target = itarget[SIG_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SIG_W-1:0] draw_signal();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      5: return $signed($urandom_range(0, 2048)) - 32'sd1024;
      6, 7: return $urandom();
      8: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return -32'sd1;
          3: return 32'sd1;
          default: return 32'sd0;
        endcase
      end
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic [SIG_W-1:0] draw_gain(input bit allow_negative);
    logic signed [SIG_W-1:0] g;
    g = $urandom_range(0, 32'h0800_0000);
    if (allow_negative && $urandom_range(0, 1) == 1) g = -g;
    return g;
  endfunction

  task automatic offer_input(input logic signed [SIG_W-1:0] target,
                             input logic signed [SIG_W-1:0] speed,
                             input logic signed [SIG_W-1:0] current,
                             output ctrl_result_t predicted);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {current, speed, target};
    do @(posedge clk); while (!in_tready);
    predicted = control_tick(target, speed, current);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [SIG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_SPEED_KP:        speed_kp_q = value;
      REG_SPEED_KI_DT:     speed_ki_q = value;
      REG_CURRENT_KP:      current_kp_q = value;
      REG_CURRENT_KI_DT:   current_ki_q = value;
      REG_EMF_CONSTANT:    emf_q = value;
      REG_VOLTAGE_CEILING: ceiling_q = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [SIG_W-1:0] s_kp, input logic [SIG_W-1:0] s_ki,
                               input logic [SIG_W-1:0] c_kp, input logic [SIG_W-1:0] c_ki,
                               input logic [SIG_W-1:0] emf, input logic [SIG_W-1:0] ceiling);
    while (pending_results.size() != 0) @(posedge clk);
    write_reg(REG_SPEED_KP, s_kp);
    write_reg(REG_SPEED_KI_DT, s_ki);
    write_reg(REG_CURRENT_KP, c_kp);
    write_reg(REG_CURRENT_KI_DT, c_ki);
    write_reg(REG_EMF_CONSTANT, emf);
    write_reg(REG_VOLTAGE_CEILING, ceiling);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    ctrl_result_t            predicted;
    logic signed [SIG_W-1:0] target;
    logic signed [SIG_W-1:0] speed;
    for (int k = 0; k < count; k++) begin
      target = draw_signal();
      if ($urandom_range(0, 2) == 0) begin
        speed = target - ($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      end else begin
        speed = draw_signal();
      end
      offer_input(target, speed, draw_signal(), predicted);
      pending_results.push_back(predicted);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin : result_sink
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending: tdata %h tuser %b",
               out_tdata, out_tuser);
        fault_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_tdata[SIG_W-1:0] !== head_result.voltage_command) begin
          $error("voltage_command: expected %0d, got %0d",
                 head_result.voltage_command, $signed(out_tdata[SIG_W-1:0]));
          fault_count++;
        end
        if (out_tdata[2*SIG_W-1:SIG_W] !== head_result.current_target) begin
          $error("current_target: expected %0d, got %0d",
                 head_result.current_target, $signed(out_tdata[2*SIG_W-1:SIG_W]));
          fault_count++;
        end
        if (out_tuser[0] !== head_result.voltage_clamped) begin
          $error("voltage_clamped: expected %0b, got %0b",
                 head_result.voltage_clamped, out_tuser[0]);
          fault_count++;
        end
      end
    end
  end

  initial begin : stimulus
    ctrl_result_t predicted;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_input(stim_table[i].target, stim_table[i].speed, stim_table[i].current, predicted);
      pending_results.push_back(stim_table[i].typed ? stim_table[i].expected : predicted);
    end
    in_tvalid <= 1'b0;

    load_settings(draw_gain(0), $urandom_range(0, 32'h0004_0000), draw_gain(0),
                  $urandom_range(0, 32'h0004_0000), draw_gain(0),
                  $urandom_range(32'h0010_0000, 32'h0100_0000));
    hold_request = 1'b1;
    run_random(200);

    load_settings(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    run_random(160);

    load_settings(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    run_random(160);

    load_settings('0, '0, '0, '0, '0, '0);
    run_random(160);

    load_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    run_random(200);

    load_settings(draw_gain(1), draw_gain(1) >>> 6, draw_gain(1), draw_gain(1) >>> 6,
                  draw_gain(1), draw_signal());
    run_random(200);

    idle_on = 1'b0;
    load_settings(RST_SPEED_KP, RST_SPEED_KI_DT, RST_CURRENT_KP, RST_CURRENT_KI_DT,
                  RST_EMF_CONSTANT, RST_VOLTAGE_CEILING);
    run_random(200);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* sim.f */
hdl/cpisc_pkg.sv
hdl/cpisc_dp.sv
hdl/cpisc_ctrl.sv
hdl/cascaded_pi_speed_current_control.sv
tb/cascaded_pi_speed_current_control_test.sv
